/* hdl/owrc_pkg.sv */
// ----------------------------------------------------------------------------
// owrc_pkg
// shared types and constants of the omni wheel rpm commander
// ----------------------------------------------------------------------------
`default_nettype none

package owrc_pkg;

  localparam int WHEELS  = 4;
  localparam int WHEEL_W = $clog2(WHEELS);

  localparam int VEL_W    = 20;
  localparam int LIN_W    = VEL_W + 1;
  localparam int ROT_W    = VEL_W + 17;
  localparam int SPEED_W  = 38;
  localparam int HALF_W   = SPEED_W / 2;
  localparam int EPM_W    = 20;
  localparam int PART_W   = HALF_W + EPM_W;
  localparam int PROD_W   = SPEED_W + EPM_W;
  localparam int FRAC_W   = 28;
  localparam int QUOT_W   = PROD_W - FRAC_W;
  localparam int TARGET_W = EPM_W + 1;
  localparam int CNT_W    = 16;

  localparam int ID_W     = 29;
  localparam int DATA_W   = 32;
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] CMD_SET_RPM = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_RADIUS = 3'd0,
    REG_ERPM_PER_MPS = 3'd1,
    REG_MAX_ERPM     = 3'd2,
    REG_SEND_PERIOD  = 3'd3,
    REG_WDOG_PERIOD  = 3'd4,
    REG_TIMEOUT      = 3'd5,
    REG_WHEEL_IDS    = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ACT_COMMAND = 1'b0,
    ACT_TICK    = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_ROT,
    B_LIN,
    B_MLO,
    B_MHI,
    B_ERPM,
    B_SEND,
    B_WDOG
  } back_state_e;

  typedef struct packed {
    logic [15:0] wheel_radius;
    logic [19:0] erpm_per_mps;
    logic [19:0] erpm_limit;
    logic [15:0] send_period;
    logic [15:0] wdog_period;
    logic [15:0] timeout;
    logic [31:0] wheel_ids;
  } cfg_t;

  typedef struct packed {
    action_e                   action;
    logic signed [LIN_W-1:0]   sum_xy;
    logic signed [LIN_W-1:0]   dif_xy;
    logic signed [VEL_W-1:0]   yaw;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_out_t;

endpackage

`default_nettype wire

/* hdl/owrc_front.sv */
// ----------------------------------------------------------------------------
// owrc_front
// accepts input transactions, classifies them and queues them for execution
// ----------------------------------------------------------------------------
`default_nettype none

module owrc_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [owrc_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  wire logic                             s_axis_tuser,
  output owrc_pkg::queue_out_t                  queue_o,
  input  wire logic                             pop_i
);

  localparam int DEPTH = 2;

  owrc_pkg::entry_t mem_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;
  logic             do_pop;
  owrc_pkg::entry_t entry_in;

  logic signed [owrc_pkg::VEL_W-1:0] vx, vy;

  assign vx = s_axis_tdata[19:0];
  assign vy = s_axis_tdata[39:20];

  always_comb begin
    entry_in.action = owrc_pkg::action_e'(s_axis_tuser);
    entry_in.sum_xy = owrc_pkg::LIN_W'(vx) + owrc_pkg::LIN_W'(vy);
    entry_in.dif_xy = owrc_pkg::LIN_W'(vx) - owrc_pkg::LIN_W'(vy);
    entry_in.yaw    = s_axis_tdata[59:40];
  end

  assign s_axis_tready = (count_q != 2'(DEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign do_pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry_in;
    end
  end

  assign queue_o.valid = (count_q != 2'd0);
  assign queue_o.entry = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hdl/owrc_back.sv */
// ----------------------------------------------------------------------------
// owrc_back
// executes queued commands and ticks: wheel targets, counters, frame bursts
// ----------------------------------------------------------------------------
`default_nettype none

module owrc_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire owrc_pkg::cfg_t                   cfg_i,
  input  wire owrc_pkg::queue_out_t             queue_i,
  output logic                                  pop_o,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [owrc_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  output logic [owrc_pkg::WHEEL_W-1:0]          m_axis_tuser,
  output logic                                  m_axis_tlast
);

  localparam int SW = owrc_pkg::SPEED_W;
  localparam int HW = owrc_pkg::HALF_W;
  localparam int TW = owrc_pkg::TARGET_W;
  localparam int CW = owrc_pkg::CNT_W;
  localparam int WW = owrc_pkg::WHEEL_W;

  owrc_pkg::back_state_e state_q, state_d;

  logic signed [TW-1:0]  targets_q [owrc_pkg::WHEELS];
  logic                  tgt_we;
  logic signed [TW-1:0]  tgt_wdata;
  logic                  tgt_clear;

  logic [CW-1:0] age_q, age_d;
  logic [CW-1:0] send_ph_q, send_ph_d;
  logic [CW-1:0] wdog_ph_q, wdog_ph_d;
  logic [WW-1:0] wheel_q, wheel_d;
  logic          zero_q, zero_d;

  owrc_pkg::entry_t entry_q;
  logic             entry_we;

  logic signed [owrc_pkg::ROT_W-1:0]  rot_q, rot_d;
  logic [SW-1:0]                      mag_q, mag_d;
  logic                               neg_q, neg_d;
  logic [owrc_pkg::PART_W-1:0]        plo_q, plo_d, phi_q, phi_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_load;
  logic [owrc_pkg::ID_W-1:0]   out_id_q;
  logic [owrc_pkg::DATA_W-1:0] out_data_q;
  logic [WW-1:0]           out_idx_q;
  logic                    out_last_q;

  // tick arithmetic
  logic [CW-1:0] age_inc, send_nx, wdog_nx;
  logic          send_fire, wdog_fire;

  // per wheel arithmetic
  logic signed [owrc_pkg::LIN_W-1:0] lin_sel;
  logic signed [SW-1:0]              lin_ext, rot_ext, speed;
  logic                              rot_sub;
  logic [owrc_pkg::PROD_W-1:0]       prod;
  logic [owrc_pkg::QUOT_W-1:0]       quot;
  logic [owrc_pkg::EPM_W-1:0]        clamped;
  logic signed [TW-1:0]              erpm;

  logic [7:0]  frame_wid;
  logic [owrc_pkg::ID_W-1:0] frame_id;

  assign age_inc   = (age_q == owrc_pkg::CNT_MAX) ? age_q : age_q + 1'b1;
  assign send_nx   = send_ph_q + 1'b1;
  assign wdog_nx   = wdog_ph_q + 1'b1;
  assign send_fire = (send_nx >= cfg_i.send_period) || (send_nx == '0);
  assign wdog_fire = (wdog_nx >= cfg_i.wdog_period) || (wdog_nx == '0);

  // front left and rear right wheels (0 and 3) use vx - vy, the other two vx + vy
  assign lin_sel = (wheel_q == 2'd0 || wheel_q == 2'd3) ? entry_q.dif_xy : entry_q.sum_xy;
  assign rot_sub = !wheel_q[0];
  assign lin_ext = SW'($signed({lin_sel, 16'b0}));
  assign rot_ext = SW'(rot_q);
  assign speed   = rot_sub ? lin_ext - rot_ext : lin_ext + rot_ext;

  assign prod    = {phi_q, HW'(0)} + owrc_pkg::PROD_W'(plo_q);
  assign quot    = prod[owrc_pkg::PROD_W-1:owrc_pkg::FRAC_W];
  assign clamped = (quot > owrc_pkg::QUOT_W'(cfg_i.erpm_limit)) ? cfg_i.erpm_limit
                                                                 : quot[owrc_pkg::EPM_W-1:0];
  assign erpm    = neg_q ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});

  assign frame_wid = cfg_i.wheel_ids[8*wheel_q +: 8];
  assign frame_id  = {19'd0, owrc_pkg::CMD_SET_RPM, frame_wid};

  always_comb begin
    state_d     = state_q;
    age_d       = age_q;
    send_ph_d   = send_ph_q;
    wdog_ph_d   = wdog_ph_q;
    wheel_d     = wheel_q;
    zero_d      = zero_q;
    rot_d       = rot_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    plo_d       = plo_q;
    phi_d       = phi_q;
    pop_o       = 1'b0;
    entry_we    = 1'b0;
    tgt_we      = 1'b0;
    tgt_wdata   = erpm;
    tgt_clear   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      owrc_pkg::B_IDLE: begin
        if (queue_i.valid) begin
          pop_o    = 1'b1;
          entry_we = 1'b1;
          wheel_d  = '0;
          if (queue_i.entry.action == owrc_pkg::ACT_COMMAND) begin
            age_d   = '0;
            state_d = owrc_pkg::B_ROT;
          end else begin
            age_d     = age_inc;
            send_ph_d = send_fire ? '0 : send_nx;
            wdog_ph_d = wdog_fire ? '0 : wdog_nx;
            zero_d    = wdog_fire && (age_inc > cfg_i.timeout);
            state_d   = send_fire ? owrc_pkg::B_SEND : owrc_pkg::B_WDOG;
          end
        end
      end
      owrc_pkg::B_ROT: begin
        rot_d   = entry_q.yaw * $signed({1'b0, cfg_i.wheel_radius});
        state_d = owrc_pkg::B_LIN;
      end
      owrc_pkg::B_LIN: begin
        neg_d   = speed[SW-1];
        mag_d   = speed[SW-1] ? SW'(-speed) : SW'(speed);
        state_d = owrc_pkg::B_MLO;
      end
      owrc_pkg::B_MLO: begin
        plo_d   = mag_q[HW-1:0] * cfg_i.erpm_per_mps;
        state_d = owrc_pkg::B_MHI;
      end
      owrc_pkg::B_MHI: begin
        phi_d   = mag_q[SW-1:HW] * cfg_i.erpm_per_mps;
        state_d = owrc_pkg::B_ERPM;
      end
      owrc_pkg::B_ERPM: begin
        tgt_we  = 1'b1;
        wheel_d = wheel_q + 1'b1;
        state_d = (wheel_q == WW'(owrc_pkg::WHEELS - 1)) ? owrc_pkg::B_IDLE
                                                         : owrc_pkg::B_LIN;
      end
      owrc_pkg::B_SEND: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          wheel_d     = wheel_q + 1'b1;
          if (wheel_q == WW'(owrc_pkg::WHEELS - 1)) begin
            state_d = owrc_pkg::B_WDOG;
          end
        end
      end
      owrc_pkg::B_WDOG: begin
        tgt_clear = zero_q;
        state_d   = owrc_pkg::B_IDLE;
      end
      default: begin
        state_d = owrc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= owrc_pkg::B_IDLE;
      age_q       <= owrc_pkg::CNT_MAX;
      send_ph_q   <= '0;
      wdog_ph_q   <= '0;
      wheel_q     <= '0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < owrc_pkg::WHEELS; i++) begin
        targets_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      age_q       <= age_d;
      send_ph_q   <= send_ph_d;
      wdog_ph_q   <= wdog_ph_d;
      wheel_q     <= wheel_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      if (tgt_clear) begin
        for (int i = 0; i < owrc_pkg::WHEELS; i++) begin
          targets_q[i] <= '0;
        end
      end else if (tgt_we) begin
        targets_q[wheel_q] <= tgt_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (entry_we) begin
      entry_q <= queue_i.entry;
    end
    rot_q <= rot_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    plo_q <= plo_d;
    phi_q <= phi_d;
    if (out_load) begin
      out_id_q   <= frame_id;
      out_data_q <= owrc_pkg::DATA_W'(targets_q[wheel_q]);
      out_idx_q  <= wheel_q;
      out_last_q <= (wheel_q == WW'(owrc_pkg::WHEELS - 1));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_data_q, out_id_q};
  assign m_axis_tuser  = out_idx_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* hdl/omni_wheel_rpm_commander.sv */
// ----------------------------------------------------------------------------
// omni_wheel_rpm_commander
// four wheel omni inverse kinematics with periodic rpm frames and a watchdog
// ----------------------------------------------------------------------------
// usage
// s_axis carries velocity commands (tuser 0) and one millisecond ticks
// (tuser 1); tdata holds vx, vy, wz in signed q8.12 from the lowest bit up.
// in the back end a command is taken from the queue, wz*radius is formed,
// then each wheel in turn gets its signed sum and magnitude, the two
// partial products of the erpm scaling, then clamp and store.
// a tick goes through the watchdog step, after the send step if it sends.
// a send tick gives four frames on m_axis, one per cycle while tready is
// high, fl first and tlast on rr. a two entry queue sits between input and
// execution, so input is taken while frames wait; input stalls only when
// the queue is full. a stalled receiver holds the current frame in the
// output register and pauses the burst.
// reset clears targets to zero, phases to zero, command age to saturated,
// and loads the default configuration. cfg writes go to the register file
// at once; the user must make them only while idle, the block does not check.
// ----------------------------------------------------------------------------
`default_nettype none

module omni_wheel_rpm_commander (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [owrc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [owrc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // velocity_x[19:0], velocity_y[39:20], yaw_rate[59:40], zero pad
  input  wire logic [owrc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // action
  input  wire logic                              s_axis_tuser,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // frame_id[28:0], frame_data[60:29], zero pad
  output logic [owrc_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  // wheel_index
  output logic [owrc_pkg::WHEEL_W-1:0]           m_axis_tuser,
  output logic                                   m_axis_tlast
);

  owrc_pkg::cfg_t       cfg_q;
  owrc_pkg::queue_out_t queue;
  logic                 pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wheel_radius <= 16'd9830;
      cfg_q.erpm_per_mps <= 20'd20000;
      cfg_q.erpm_limit   <= 20'd30000;
      cfg_q.send_period  <= 16'd30;
      cfg_q.wdog_period  <= 16'd100;
      cfg_q.timeout      <= 16'd200;
      cfg_q.wheel_ids    <= 32'h0403_0201;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        owrc_pkg::REG_WHEEL_RADIUS: cfg_q.wheel_radius <= cfg_data_i[15:0];
        owrc_pkg::REG_ERPM_PER_MPS: cfg_q.erpm_per_mps <= cfg_data_i[19:0];
        owrc_pkg::REG_MAX_ERPM:     cfg_q.erpm_limit   <= cfg_data_i[19:0];
        owrc_pkg::REG_SEND_PERIOD:  cfg_q.send_period  <= cfg_data_i[15:0];
        owrc_pkg::REG_WDOG_PERIOD:  cfg_q.wdog_period  <= cfg_data_i[15:0];
        owrc_pkg::REG_TIMEOUT:      cfg_q.timeout      <= cfg_data_i[15:0];
        owrc_pkg::REG_WHEEL_IDS:    cfg_q.wheel_ids    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  owrc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .queue_o       (queue),
    .pop_i         (pop)
  );

  owrc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .queue_i       (queue),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* hdl/owrc_checker.sv */
// ----------------------------------------------------------------------------
// owrc_checker
// port level checks of the frame output, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module owrc_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [owrc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input wire logic [owrc_pkg::WHEEL_W-1:0]     m_axis_tuser,
  input wire logic                             m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("frame changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 2'd3)))
    else $error("tlast not on the rear right frame");

  a_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[28:8] == 21'(owrc_pkg::CMD_SET_RPM))
                      && (m_axis_tdata[63:61] == 3'd0)
                      && ((m_axis_tdata[60:49] == 12'h000) || (m_axis_tdata[60:49] == 12'hFFF)))
    else $error("malformed frame id or erpm out of range");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
    else $error("burst interrupted or out of order");

endmodule

bind omni_wheel_rpm_commander owrc_checker u_owrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
